@@ hw/rtl/evt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the election vote tally.
// Depends on nothing; every other file of the block but evt_ram imports it.

package evt_pkg;

    localparam int TERM_W  = 63;
    localparam int COUNT_W = 6;
    localparam int VOTER_W = 5;
    localparam int CFG_IDX_W = 2;

    typedef logic [TERM_W-1:0]    term_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [VOTER_W-1:0]   voter_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_VOTER_LIMIT = 2'd0;
    localparam cfg_idx_t CFG_QUORUM      = 2'd1;
    localparam cfg_idx_t CFG_OWN_TERM    = 2'd2;

    localparam count_t VOTER_LIMIT_RESET = 6'd1;
    localparam count_t QUORUM_RESET      = 6'd1;

    typedef enum logic [2:0] {
        ST_COUNTED  = 3'd0,
        ST_DUP      = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_TOO_MANY = 3'd3,
        ST_CANCEL   = 3'd4
    } status_t;

    typedef struct packed {
        voter_t voter;
        logic   transport_failed;
        logic   peer_error;
        logic   identity_mismatch;
        logic   granted;
        term_t  peer_term;
    } vote_t;

    typedef struct packed {
        status_t status;
        logic    decided_now;
        logic    decision;
        term_t   result_term;
        count_t  yes_count;
        count_t  no_count;
        logic    all_in;
    } result_t;

    typedef struct packed {
        count_t voter_limit;
        count_t quorum;
        term_t  own_term;
    } cfg_regs_t;

    typedef struct packed {
        count_t yes_tally;
        count_t no_tally;
        term_t  highest_term;
        logic   done;
    } tally_state_t;

    typedef struct packed {
        logic has_voted;
        logic vote_value;
    } ballot_t;

endpackage

`default_nettype wire

@@ hw/rtl/evt_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Configuration write channel of the election vote tally.
// Depends on evt_pkg.

interface evt_cfg_if;
    import evt_pkg::*;

    logic     valid;
    logic     ready;
    cfg_idx_t index;
    term_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/evt_vote_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Vote response channel of the election vote tally, one response per word.
// Depends on evt_pkg.

interface evt_vote_if;
    import evt_pkg::*;

    logic   valid;
    logic   ready;
    voter_t voter;
    logic   transport_failed;
    logic   peer_error;
    logic   identity_mismatch;
    logic   granted;
    term_t  peer_term;

    modport source (output valid, output voter, output transport_failed,
                    output peer_error, output identity_mismatch, output granted,
                    output peer_term, input ready);
    modport sink   (input valid, input voter, input transport_failed,
                    input peer_error, input identity_mismatch, input granted,
                    input peer_term, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/evt_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the election vote tally, one word per vote response.
// Depends on evt_pkg.

interface evt_result_if;
    import evt_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    logic    decided_now;
    logic    decision;
    term_t   result_term;
    count_t  yes_count;
    count_t  no_count;
    logic    all_in;

    modport source (output valid, output status, output decided_now,
                    output decision, output result_term, output yes_count,
                    output no_count, output all_in, input ready);
    modport sink   (input valid, input status, input decided_now,
                    input decision, input result_term, input yes_count,
                    input no_count, input all_in, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/election_vote_tally.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Top level of the election vote tally: control, configuration and tallies.
// Depends on evt_pkg, the three channel interfaces, evt_ballot_store and
// evt_tally_eval.
//
//  Channel   Direction  Word
//  cfg       in         register index and write data
//  vote      in         one vote response
//  result    out        status, decision and tallies for that response
//
// Each response passes through the ballot RAM read, then evaluation and
// write-back. A new response is taken while the previous result still waits
// in the output register; evaluation holds while that register is full.
// Reset clears all ballots and tallies at once and starts a new election.

module election_vote_tally #(
    parameter int MAX_VOTERS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    evt_cfg_if.sink     cfg,
    evt_vote_if.sink    vote,
    evt_result_if.source result
);
    import evt_pkg::*;

    localparam int VIDX_W = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    cfg_regs_t    cfg_reg;
    tally_state_t tally_reg;
    tally_state_t tally_next;
    vote_t        item_reg;
    result_t      res_reg;
    result_t      eval_res;
    ballot_t      ballot;
    logic         res_valid_reg;
    logic         accept;
    logic         load;
    logic         in_range;
    logic         record;
    logic         record_yes;
    logic [VIDX_W-1:0] vote_addr;
    logic [VIDX_W-1:0] item_addr;

    assign cfg.ready  = 1'b1;
    assign vote.ready = (state_reg == S_IDLE);
    assign accept     = vote.valid && vote.ready;
    assign load       = (state_reg == S_EVAL) && (!res_valid_reg || result.ready);
    assign vote_addr  = VIDX_W'(vote.voter);
    assign item_addr  = VIDX_W'(item_reg.voter);
    assign in_range   = 9'(item_reg.voter) < 9'(MAX_VOTERS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voter_limit <= VOTER_LIMIT_RESET;
            cfg_reg.quorum      <= QUORUM_RESET;
            cfg_reg.own_term    <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_VOTER_LIMIT: cfg_reg.voter_limit <= cfg.data[COUNT_W-1:0];
                CFG_QUORUM:      cfg_reg.quorum      <= cfg.data[COUNT_W-1:0];
                CFG_OWN_TERM:    cfg_reg.own_term    <= cfg.data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.voter             <= vote.voter;
            item_reg.transport_failed  <= vote.transport_failed;
            item_reg.peer_error        <= vote.peer_error;
            item_reg.identity_mismatch <= vote.identity_mismatch;
            item_reg.granted           <= vote.granted;
            item_reg.peer_term         <= vote.peer_term;
        end
        if (load)
        begin
            res_reg <= eval_res;
        end
    end

    evt_ballot_store #(
        .MAX_VOTERS (MAX_VOTERS)
    ) u_ballot_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (vote_addr),
        .rd_ballot (ballot),
        .wr_en     (load && record),
        .wr_addr   (item_addr),
        .wr_value  (record_yes)
    );

    evt_tally_eval u_tally_eval (
        .item       (item_reg),
        .in_range   (in_range),
        .ballot     (ballot),
        .state      (tally_reg),
        .cfg        (cfg_reg),
        .result     (eval_res),
        .state_next (tally_next),
        .record     (record),
        .record_yes (record_yes)
    );

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EVAL : S_IDLE;
            S_EVAL:  state_next = load ? S_IDLE : S_EVAL;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tally_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                tally_reg     <= tally_next;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.status      = res_reg.status;
    assign result.decided_now = res_reg.decided_now;
    assign result.decision    = res_reg.decision;
    assign result.result_term = res_reg.result_term;
    assign result.yes_count   = res_reg.yes_count;
    assign result.no_count    = res_reg.no_count;
    assign result.all_in      = res_reg.all_in;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !vote.ready)
        else $error("second response taken while one is being evaluated");

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg.done |=> tally_reg.done)
        else $error("election result flag cleared without reset");

    a_decide_once: assert property (@(posedge clk) disable iff (!rst_n)
        load && eval_res.decided_now |-> !tally_reg.done)
        else $error("election result reported a second time");

    a_yes_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> tally_reg.yes_tally >= $past(tally_reg.yes_tally))
        else $error("yes tally decreased");

    a_decision_qualified: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.decision |-> result.decided_now)
        else $error("win flagged on a word that reports no decision");

endmodule

`default_nettype wire

@@ hw/rtl/evt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module evt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                               rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/evt_ballot_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Per-voter ballot store: has-voted flags in flip-flops, vote values in a RAM.
// Depends on evt_pkg and evt_ram.

module evt_ballot_store #(
    parameter int MAX_VOTERS = 32
) (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire logic                                              rd_en,
    input  wire logic [((MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1)-1:0] rd_addr,
    output evt_pkg::ballot_t                                       rd_ballot,
    input  wire logic                                              wr_en,
    input  wire logic [((MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1)-1:0] wr_addr,
    input  wire logic                                              wr_value
);
    import evt_pkg::*;

    logic [MAX_VOTERS-1:0] voted_reg;
    logic [MAX_VOTERS-1:0] voted_next;
    logic                  voted_rd_reg;
    logic                  value_rd;

    always_comb
    begin
        voted_next = voted_reg;
        if (wr_en)
        begin
            voted_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voted_reg    <= '0;
            voted_rd_reg <= 1'b0;
        end
        else
        begin
            voted_reg <= voted_next;
            if (rd_en)
            begin
                voted_rd_reg <= voted_reg[rd_addr];
            end
        end
    end

    evt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_VOTERS)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (value_rd)
    );

    assign rd_ballot.has_voted  = voted_rd_reg;
    assign rd_ballot.vote_value = value_rd;

endmodule

`default_nettype wire

@@ hw/rtl/evt_tally_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Evaluation of one vote response against the stored ballot and the tallies.
// Depends on evt_pkg.

module evt_tally_eval (
    input  wire evt_pkg::vote_t        item,
    input  wire logic                  in_range,
    input  wire evt_pkg::ballot_t      ballot,
    input  wire evt_pkg::tally_state_t state,
    input  wire evt_pkg::cfg_regs_t    cfg,
    output evt_pkg::result_t           result,
    output evt_pkg::tally_state_t      state_next,
    output logic                       record,
    output logic                       record_yes
);
    import evt_pkg::*;

    logic                 failed;
    logic                 cancel;
    logic                 full;
    logic                 won;
    logic                 lost;
    logic [COUNT_W:0]     voted_sum;
    logic [COUNT_W:0]     final_sum;
    logic [COUNT_W:0]     lose_sum;
    status_t              rec_status;
    term_t                highest_next;

    always_comb
    begin
        failed     = item.transport_failed | item.peer_error | item.identity_mismatch;
        record_yes = !failed && item.granted;
        cancel     = !failed && !item.granted && (item.peer_term > cfg.own_term);

        highest_next = state.highest_term;
        if (!failed && (item.peer_term > state.highest_term))
        begin
            highest_next = item.peer_term;
        end

        voted_sum = {1'b0, state.yes_tally} + {1'b0, state.no_tally};
        full      = voted_sum >= {1'b0, cfg.voter_limit};

        record = 1'b0;
        if (!in_range)
        begin
            rec_status = ST_TOO_MANY;
        end
        else if (ballot.has_voted)
        begin
            rec_status = (ballot.vote_value == record_yes) ? ST_DUP : ST_CONFLICT;
        end
        else if (full)
        begin
            rec_status = ST_TOO_MANY;
        end
        else
        begin
            rec_status = ST_COUNTED;
            record     = !cancel;
        end

        state_next              = state;
        state_next.highest_term = highest_next;
        if (record && record_yes)
        begin
            state_next.yes_tally = state.yes_tally + COUNT_W'(1);
        end
        if (record && !record_yes)
        begin
            state_next.no_tally = state.no_tally + COUNT_W'(1);
        end

        won      = state_next.yes_tally >= cfg.quorum;
        lose_sum = {1'b0, state_next.no_tally} + {1'b0, cfg.quorum};
        lost     = lose_sum > {1'b0, cfg.voter_limit};

        result.status      = cancel ? ST_CANCEL : rec_status;
        result.decided_now = 1'b0;
        result.decision    = 1'b0;
        result.result_term = highest_next;
        if (cancel && !state.done)
        begin
            result.decided_now = 1'b1;
            result.result_term = item.peer_term;
        end
        else if (!state.done && (won || lost))
        begin
            result.decided_now = 1'b1;
            result.decision    = won;
        end
        state_next.done = state.done | result.decided_now;

        final_sum        = {1'b0, state_next.yes_tally} + {1'b0, state_next.no_tally};
        result.yes_count = state_next.yes_tally;
        result.no_count  = state_next.no_tally;
        result.all_in    = final_sum == {1'b0, cfg.voter_limit};
    end

endmodule

`default_nettype wire
